// ----- rtl/lfsp_pkg.sv -----
// ---------------------------------------------------------------------------
// lfsp_pkg
// Shared widths, protocol constants and register map of the LED frame
// stream parser.
// ---------------------------------------------------------------------------
package lfsp_pkg;

  // Payload widths
  localparam int BYTE_W      = 8;
  localparam int INDEX_W     = 12;
  localparam int LEFT_W      = 18;
  localparam int LED_COUNT_W = 11;

  // APB port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map: register index is paddr[PADDR_W-1:2]
  localparam logic [PADDR_W-3:0] REG_LED_COUNT = 1'b0;

  // Reset and default values
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RESET  = 11'd1024;
  localparam int unsigned            MAX_LEDS_DEFAULT = 1024;

  // Frame header bytes
  localparam logic [BYTE_W-1:0] MAGIC_0   = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] MAGIC_1   = 8'h64;  // 'd'
  localparam logic [BYTE_W-1:0] MAGIC_2   = 8'h61;  // 'a'
  localparam logic [BYTE_W-1:0] CHECK_XOR = 8'h55;

  // Largest frame store bound, keeps the store index from wrapping
  localparam logic [INDEX_W-1:0] BOUND_CAP = 12'hFFF;

  // One result item
  typedef struct packed {
    logic               write_valid;
    logic [INDEX_W-1:0] write_index;
    logic [BYTE_W-1:0]  write_value;
    logic               clear_frame;
    logic               latch;
  } result_t;

endpackage

// ----- rtl/lfsp_if.sv -----
// ---------------------------------------------------------------------------
// lfsp_if
// Valid/ready channels of the LED frame stream parser: one for received
// serial bytes, one for frame store commands.
// ---------------------------------------------------------------------------
interface lfsp_byte_if import lfsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lfsp_result_if import lfsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_valid;
  logic [INDEX_W-1:0] write_index;
  logic [BYTE_W-1:0]  write_value;
  logic               clear_frame;
  logic               latch;

  modport source (output valid, output write_valid, output write_index,
                  output write_value, output clear_frame, output latch,
                  input ready);
  modport sink   (input valid, input write_valid, input write_index,
                  input write_value, input clear_frame, input latch,
                  output ready);
endinterface

// ----- rtl/lfsp_cfg.sv -----
// ---------------------------------------------------------------------------
// lfsp_cfg
// APB register block: holds led_count and the derived frame store bound
// 3*min(led_count, MAX_LEDS), capped at the largest store index.
// ---------------------------------------------------------------------------
module lfsp_cfg import lfsp_pkg::*; #(
  parameter int unsigned MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [INDEX_W-1:0] bound
);

  // LED limit seen through the 11-bit register
  localparam int unsigned CountMax = (1 << LED_COUNT_W) - 1;
  localparam int unsigned LedLimitInt = (MAX_LEDS > CountMax) ? CountMax : MAX_LEDS;
  localparam logic [LED_COUNT_W-1:0] LedLimit = LED_COUNT_W'(LedLimitInt);

  logic [LED_COUNT_W-1:0] led_count;
  logic                   wr_en;
  logic                   sel_led_count;

  // Store bound for a given LED count
  function automatic logic [INDEX_W-1:0] bound_of(input logic [LED_COUNT_W-1:0] cnt);
    logic [LED_COUNT_W-1:0] n;
    logic [LED_COUNT_W+1:0] b;
    n = (cnt > LedLimit) ? LedLimit : cnt;
    b = {1'b0, n, 1'b0} + {2'b00, n};
    if (b > {{(LED_COUNT_W+2-INDEX_W){1'b0}}, BOUND_CAP}) begin
      return BOUND_CAP;
    end
    return b[INDEX_W-1:0];
  endfunction

  assign pready        = 1'b1;
  assign sel_led_count = (paddr[PADDR_W-1:2] == REG_LED_COUNT);
  assign wr_en         = psel && penable && pwrite && pready;

  // Write led_count and refresh the bound
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= LED_COUNT_RESET;
      bound     <= bound_of(LED_COUNT_RESET);
    end else if (wr_en && sel_led_count) begin
      led_count <= pwdata[LED_COUNT_W-1:0];
      bound     <= bound_of(pwdata[LED_COUNT_W-1:0]);
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (sel_led_count) begin
      prdata = {{(PDATA_W-LED_COUNT_W){1'b0}}, led_count};
    end
  end

endmodule

// ----- rtl/lfsp_parser.sv -----
// ---------------------------------------------------------------------------
// lfsp_parser
// Header search, count capture, checksum check and data phase. Each
// accepted byte is parsed combinationally into a result register.
// ---------------------------------------------------------------------------
module lfsp_parser import lfsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [INDEX_W-1:0] bound,
  lfsp_byte_if.sink          serial,
  lfsp_result_if.source      cmd
);

  typedef enum logic [2:0] {
    H_MAGIC0,
    H_MAGIC1,
    H_MAGIC2,
    H_COUNT_HI,
    H_COUNT_LO,
    H_CHECK
  } hdr_t;

  hdr_t               hdr, hdr_next;
  logic [BYTE_W-1:0]  count_high, count_high_next;
  logic [BYTE_W-1:0]  count_low, count_low_next;
  logic               in_data, in_data_next;
  logic [LEFT_W-1:0]  bytes_left, bytes_left_next;
  logic [INDEX_W-1:0] store_index, store_index_next;
  result_t            res, res_next;
  logic               res_valid;
  logic               accept;
  logic [BYTE_W-1:0]  b;
  logic [LEFT_W-2:0]  frame_leds;

  assign b            = serial.data_byte;
  assign serial.ready = !res_valid || cmd.ready;
  assign accept       = serial.valid && serial.ready;

  // LEDs announced by the header: count + 1
  assign frame_leds = {1'b0, count_high, count_low} + (LEFT_W-1)'(1);

  // Parse one byte
  always_comb begin
    hdr_next         = hdr;
    count_high_next  = count_high;
    count_low_next   = count_low;
    in_data_next     = in_data;
    bytes_left_next  = bytes_left;
    store_index_next = store_index;
    res_next         = '0;
    if (in_data) begin
      if (store_index < bound) begin
        res_next.write_valid = 1'b1;
        res_next.write_index = store_index;
        res_next.write_value = b;
        store_index_next     = store_index + INDEX_W'(1);
      end
      bytes_left_next = bytes_left - LEFT_W'(1);
      if (bytes_left_next == '0) begin
        res_next.latch = 1'b1;
        in_data_next   = 1'b0;
      end
    end else begin
      unique case (hdr)
        H_MAGIC0:   hdr_next = (b == MAGIC_0) ? H_MAGIC1 : H_MAGIC0;
        H_MAGIC1:   hdr_next = (b == MAGIC_1) ? H_MAGIC2 : H_MAGIC0;
        H_MAGIC2:   hdr_next = (b == MAGIC_2) ? H_COUNT_HI : H_MAGIC0;
        H_COUNT_HI: begin
          count_high_next = b;
          hdr_next        = H_COUNT_LO;
        end
        H_COUNT_LO: begin
          count_low_next = b;
          hdr_next       = H_CHECK;
        end
        H_CHECK: begin
          // Good checksum arms 3*(count+1) data bytes
          if (b == (count_high ^ count_low ^ CHECK_XOR)) begin
            bytes_left_next      = {1'b0, frame_leds} + {frame_leds, 1'b0};
            store_index_next     = '0;
            in_data_next         = 1'b1;
            res_next.clear_frame = 1'b1;
          end
          hdr_next = H_MAGIC0;
        end
        default:    hdr_next = H_MAGIC0;
      endcase
    end
  end

  // Hold parser state and the result item
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr         <= H_MAGIC0;
      count_high  <= '0;
      count_low   <= '0;
      in_data     <= 1'b0;
      bytes_left  <= '0;
      store_index <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (accept) begin
        hdr         <= hdr_next;
        count_high  <= count_high_next;
        count_low   <= count_low_next;
        in_data     <= in_data_next;
        bytes_left  <= bytes_left_next;
        store_index <= store_index_next;
        res_valid   <= 1'b1;
      end else if (cmd.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign cmd.valid       = res_valid;
  assign cmd.write_valid = res.write_valid;
  assign cmd.write_index = res.write_index;
  assign cmd.write_value = res.write_value;
  assign cmd.clear_frame = res.clear_frame;
  assign cmd.latch       = res.latch;

`ifndef SYNTHESIS
  // Clear comes alone: never with a write or a latch
  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.clear_frame && (res.write_valid || res.latch)))
    else $error("clear_frame issued together with write or latch");

  // Data phase ends only with a latch item
  a_data_end_latch: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $fell(in_data)) |-> (res_valid && res.latch))
    else $error("data phase left without latch");

  // Data phase starts only with a clear item and a fresh index
  a_data_start_clear: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $rose(in_data)) |->
      (res_valid && res.clear_frame && store_index == '0 && bytes_left != '0))
    else $error("data phase entered without clear");

  // Header position stays at the first magic slot during the data phase
  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    (hdr == H_MAGIC0 || hdr == H_MAGIC1 || hdr == H_MAGIC2 ||
     hdr == H_COUNT_HI || hdr == H_COUNT_LO || hdr == H_CHECK) |=>
      !(in_data && hdr != H_MAGIC0))
    else $error("header position moved during data phase");
`endif

endmodule

// ----- rtl/led_frame_stream_parser_core.sv -----
// ---------------------------------------------------------------------------
// led_frame_stream_parser_core
// Parses a framed serial LED stream into frame store writes, clear and
// latch commands, with an APB register for the strip length.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ---------------------------------------------
//   serial   in   valid/ready    data_byte
//   cmd      out  valid/ready    write_valid, write_index, write_value,
//                                clear_frame, latch
//   apb      in   psel/penable   led_count at byte address 0
//
// One byte per cycle unless a held item stalls input: each byte is parsed in the
// cycle it is accepted and its item sits in the result register from the next cycle.
// A held result item stalls input only while cmd.ready is low.
// Synchronous reset returns to header search with led_count = 1024.
// Write led_count only while no item is in flight.
//
module led_frame_stream_parser_core import lfsp_pkg::*; #(
  parameter int unsigned MAX_LEDS = MAX_LEDS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  lfsp_byte_if.sink          serial,
  lfsp_result_if.source      cmd,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [INDEX_W-1:0] bound;

  // Register block
  lfsp_cfg #(
    .MAX_LEDS (MAX_LEDS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bound   (bound)
  );

  // Stream parser
  lfsp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .bound  (bound),
    .serial (serial),
    .cmd    (cmd)
  );

endmodule
